// ===== hw/rtl/tmq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the timer expiry queue.
// No dependencies; every other file of the block imports this package.
package tmq_pkg;

    localparam int NOW_W     = 64;
    localparam int IV_W      = 36;
    localparam int MS_W      = 63;
    localparam int SECS_W    = 16;
    localparam int HANDLE_W  = 4;
    localparam int SLOT_W    = 4;
    localparam int MAX_OUT   = 16;

    localparam int unsigned US_PER_MS = 1000;

    localparam logic [19:0]     US_PER_S       = 20'd1000000;
    localparam logic [MS_W-1:0] MIN_TIMEOUT_MS = 63'd1000;
    localparam logic [MS_W-1:0] YEAR_MS        = 63'd31536000000;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_kind;

    localparam t_op OP_ARM   = 2'd0;
    localparam t_op OP_KILL  = 2'd1;
    localparam t_op OP_TICK  = 2'd2;
    localparam t_op OP_QUERY = 2'd3;

    localparam t_kind KIND_ARMED       = 3'd0;
    localparam t_kind KIND_KILLED      = 3'd1;
    localparam t_kind KIND_FIRED       = 3'd2;
    localparam t_kind KIND_NONE_FIRED  = 3'd3;
    localparam t_kind KIND_MIN_TIMEOUT = 3'd4;
    localparam t_kind KIND_ERROR       = 3'd5;

    typedef struct packed {
        t_op                 operation;
        logic [NOW_W-1:0]    now_us;
        logic [SECS_W-1:0]   seconds;
        logic                periodic;
        logic [HANDLE_W-1:0] handle;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [MS_W-1:0]   timeout_ms;
        logic              last;
    } t_out_item;

endpackage

// ===== hw/rtl/tmq_in_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one timer operation beat.
// Depends on tmq_pkg for the payload type.
interface tmq_in_if import tmq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tmq_out_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one timer result beat.
// Depends on tmq_pkg for the payload type.
interface tmq_out_if import tmq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tmq_div1000.sv =====
`timescale 1ns / 1ps
// Divide-by-1000 unit for the query path: shift out the factor of 8, then long
// division by 125 in 16-bit digits, one reciprocal multiply per cycle. Depends on tmq_pkg.
module tmq_div1000 import tmq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MS_W-1:0] i_dividend,
    output logic            o_busy,
    output logic [MS_W-1:0] o_quotient
);
    localparam int DIG_W  = 16;
    localparam int NDIG   = 4;
    localparam int ACC_W  = DIG_W * NDIG;
    localparam int CNT_W  = $clog2(NDIG);
    localparam int PRE_SH = 3;
    localparam int REM_W  = 7;
    localparam int T_W    = REM_W + DIG_W;
    localparam int RCP_W  = 24;
    localparam int PROD_W = T_W + RCP_W;
    localparam int RCP_SH = 30;
    localparam logic [T_W-1:0]   DIVISOR = 23'd125;
    localparam logic [RCP_W-1:0] RCP     = 24'd8589935;

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [ACC_W-1:0]  r_acc;
    logic [REM_W-1:0]  r_rem;
    logic [T_W-1:0]    w_part;
    logic [PROD_W-1:0] w_prod;
    logic [DIG_W-1:0]  w_qd;
    logic [T_W-1:0]    w_back;
    logic [T_W-1:0]    w_rem_n;

    // bring the next digit down beside the running remainder (below 125)
    assign w_part  = {r_rem, r_acc[ACC_W-1 -: DIG_W]};
    // the reciprocal gives floor(w_part / 125) exactly for w_part below 125 * 2^16
    assign w_prod  = PROD_W'(w_part) * PROD_W'(RCP);
    assign w_qd    = w_prod[RCP_SH +: DIG_W];
    assign w_back  = T_W'(w_qd) * DIVISOR;
    assign w_rem_n = w_part - w_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_acc  <= ACC_W'(i_dividend[MS_W-1:PRE_SH]);
            r_rem  <= '0;
        end else if (r_busy) begin
            // shift the quotient digit in as the dividend digit moves out
            r_acc <= {r_acc[ACC_W-DIG_W-1:0], w_qd};
            r_rem <= w_rem_n[REM_W-1:0];
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NDIG - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_acc[MS_W-1:0];
endmodule

// ===== hw/rtl/timer_expiry_queue.sv =====
`timescale 1ns / 1ps
// Timer expiry queue top level: slot table, scan sequencer and result register.
// Depends on tmq_pkg, tmq_in_if, tmq_out_if and tmq_div1000.
//
//  port   | dir | modport | beat
//  -------+-----+---------+------------------------------------------------
//  i_in   | in  | sink    | operation, now_us, seconds, periodic, handle
//  o_out  | out | source  | kind, slot, timeout_ms, last
//
// Steps: an arm computes the interval, then writes the slot; a kill checks and clears its slot; a tick
// firing k < 16 slots makes one table pass per fire and a final one.
// Query: one pass, a subtract and, unless overdue, a four-digit divide; only the pass if empty.
// Reset: synchronous, clears the active and done bits, the state and the valid flags; the expiry,
// interval and mode memories stay unknown until an arm writes them.
// Stalls: each result waits in the output register, a loading state holds while it stays full,
// and i_in.ready rises once the last beat of an item has been loaded.
module timer_expiry_queue import tmq_pkg::*; #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmq_in_if.sink     i_in,
    tmq_out_if.source  o_out
);
    localparam int SW    = $clog2(TIMER_SLOTS);
    localparam int IW    = $clog2(TIMER_SLOTS + 1);
    localparam int FIRE_W = $clog2(MAX_OUT + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ARM_MUL = 4'd1;
    localparam logic [3:0] ST_ARM_WR  = 4'd2;
    localparam logic [3:0] ST_KILL    = 4'd3;
    localparam logic [3:0] ST_SCAN    = 4'd4;
    localparam logic [3:0] ST_FIRE    = 4'd5;
    localparam logic [3:0] ST_FLUSH   = 4'd6;
    localparam logic [3:0] ST_Q_DIFF  = 4'd7;
    localparam logic [3:0] ST_Q_DIV   = 4'd8;
    localparam logic [3:0] ST_Q_EMIT  = 4'd9;

    logic [3:0] r_state;

    // latched input beat
    t_op                 r_op;
    logic [NOW_W-1:0]    r_now;
    logic [SECS_W-1:0]   r_secs;
    logic                r_per;
    logic [HANDLE_W-1:0] r_handle;

    // slot table: active and per-tick done flags in flops, the rest in memory
    logic [TIMER_SLOTS-1:0] r_active;
    logic [TIMER_SLOTS-1:0] r_done;
    logic [NOW_W-1:0]       r_mem_exp [TIMER_SLOTS];
    logic [IV_W-1:0]        r_mem_iv  [TIMER_SLOTS];
    logic                   r_mem_per [TIMER_SLOTS];
    logic [NOW_W-1:0]       r_rd_exp;
    logic [IV_W-1:0]        r_rd_iv;
    logic                   r_rd_per;

    // arm path
    logic [IV_W-1:0] r_iv;
    logic            r_free_vld;
    logic [SW-1:0]   r_free_idx;
    logic            w_free_vld;
    logic [SW-1:0]   w_free_idx;

    // scan pipeline and running minimum
    logic [IW-1:0]    r_idx;
    logic             r_cmp_vld;
    logic [SW-1:0]    r_cmp_idx;
    logic             r_best_vld;
    logic [SW-1:0]    r_best_idx;
    logic [NOW_W-1:0] r_best_exp;
    logic [IV_W-1:0]  r_best_iv;
    logic             r_best_per;
    logic             w_elig;
    logic             w_take;
    logic             w_scan_end;

    // tick bookkeeping: the newest fired slot is held back until we know
    // whether it is the final beat of the tick
    logic              r_pend_vld;
    logic [SW-1:0]     r_pend_slot;
    logic [FIRE_W-1:0] r_fired;
    logic              w_fire_go;

    // query path
    logic [MS_W-1:0]  r_ms;
    logic [NOW_W-1:0] w_diff;
    logic             w_div_start;
    logic             w_div_busy;
    logic [MS_W-1:0]  w_quo;

    // shared adder and memory write port
    logic [NOW_W-1:0] w_sum;
    logic             w_we_arm;
    logic             w_we_exp;
    logic [SW-1:0]    w_wr_idx;
    logic [SW-1:0]    w_kill_idx;
    logic             w_kill_ok;

    // result register
    logic      r_out_vld;
    t_out_item r_out;
    logic      w_out_free;
    logic      w_out_load;

    assign w_out_free = !r_out_vld || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out;

    // a new beat goes into the result register this cycle
    assign w_out_load = (((r_state == ST_ARM_WR) || (r_state == ST_KILL) ||
                          (r_state == ST_FLUSH) || (r_state == ST_Q_EMIT)) && w_out_free) ||
                        (w_fire_go && r_pend_vld);

    // lowest free slot
    always_comb begin
        w_free_vld = 1'b0;
        w_free_idx = '0;
        for (int k = TIMER_SLOTS - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                w_free_vld = 1'b1;
                w_free_idx = SW'(k);
            end
        end
    end

    // a slot competes when active; on tick also not yet fired and due
    assign w_elig = r_active[r_cmp_idx] &&
                    ((r_op == OP_QUERY) || (!r_done[r_cmp_idx] && (r_rd_exp <= r_now)));
    assign w_take = r_cmp_vld && w_elig && (!r_best_vld || (r_rd_exp < r_best_exp));
    assign w_scan_end = (r_idx == IW'(TIMER_SLOTS)) && !r_cmp_vld;

    assign w_fire_go = (r_state == ST_FIRE) && (!r_pend_vld || w_out_free);

    // one adder serves both arming and periodic re-arming
    assign w_sum    = r_now + NOW_W'((r_state == ST_ARM_WR) ? r_iv : r_best_iv);
    assign w_we_arm = (r_state == ST_ARM_WR) && w_out_free && r_free_vld;
    assign w_we_exp = w_we_arm || (w_fire_go && r_best_per);
    assign w_wr_idx = (r_state == ST_ARM_WR) ? r_free_idx : r_best_idx;

    assign w_kill_idx = SW'(r_handle);
    assign w_kill_ok  = (32'(r_handle) < TIMER_SLOTS) && r_active[w_kill_idx];

    assign w_diff      = r_best_exp - r_now;
    assign w_div_start = (r_state == ST_Q_DIFF) && !w_diff[NOW_W-1];

    tmq_div1000 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_diff[MS_W-1:0]),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // slot memories: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we_exp) begin
            r_mem_exp[w_wr_idx] <= w_sum;
        end
        if (w_we_arm) begin
            r_mem_iv[w_wr_idx]  <= r_iv;
            r_mem_per[w_wr_idx] <= r_per;
        end
        r_rd_exp <= r_mem_exp[r_idx[SW-1:0]];
        r_rd_iv  <= r_mem_iv[r_idx[SW-1:0]];
        r_rd_per <= r_mem_per[r_idx[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_vld  <= 1'b0;
            r_active   <= '0;
            r_done     <= '0;
            r_pend_vld <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            // drain the result register unless a new beat replaces it
            if (o_out.ready && !w_out_load) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_op       <= i_in.payload.operation;
                        r_now      <= i_in.payload.now_us;
                        r_secs     <= i_in.payload.seconds;
                        r_per      <= i_in.payload.periodic;
                        r_handle   <= i_in.payload.handle;
                        r_done     <= '0;
                        r_pend_vld <= 1'b0;
                        r_fired    <= '0;
                        r_idx      <= '0;
                        r_cmp_vld  <= 1'b0;
                        r_best_vld <= 1'b0;
                        unique case (i_in.payload.operation)
                            OP_ARM:   r_state <= ST_ARM_MUL;
                            OP_KILL:  r_state <= ST_KILL;
                            OP_TICK,
                            OP_QUERY: r_state <= ST_SCAN;
                            default:  r_state <= ST_IDLE;
                        endcase
                    end
                end

                ST_ARM_MUL: begin
                    // seconds * 1e6 always fits the 36-bit interval
                    r_iv       <= IV_W'(r_secs) * IV_W'(US_PER_S);
                    r_free_vld <= w_free_vld;
                    r_free_idx <= w_free_idx;
                    r_state    <= ST_ARM_WR;
                end

                ST_ARM_WR: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        if (r_free_vld) begin
                            r_active[r_free_idx] <= 1'b1;
                            r_out <= '{kind: KIND_ARMED, slot: SLOT_W'(r_free_idx),
                                       timeout_ms: '0, last: 1'b1};
                        end else begin
                            r_out <= '{kind: KIND_ERROR, slot: '0,
                                       timeout_ms: '0, last: 1'b1};
                        end
                        r_state <= ST_IDLE;
                    end
                end

                ST_KILL: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        if (w_kill_ok) begin
                            r_active[w_kill_idx] <= 1'b0;
                            r_out <= '{kind: KIND_KILLED, slot: r_handle,
                                       timeout_ms: '0, last: 1'b1};
                        end else begin
                            r_out <= '{kind: KIND_ERROR, slot: r_handle,
                                       timeout_ms: '0, last: 1'b1};
                        end
                        r_state <= ST_IDLE;
                    end
                end

                ST_SCAN: begin
                    // issue one read per cycle, compare it in the next cycle
                    if (r_idx != IW'(TIMER_SLOTS)) begin
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_idx[SW-1:0];
                        r_idx     <= r_idx + 1'b1;
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (w_take) begin
                        r_best_vld <= 1'b1;
                        r_best_idx <= r_cmp_idx;
                        r_best_exp <= r_rd_exp;
                        r_best_iv  <= r_rd_iv;
                        r_best_per <= r_rd_per;
                    end
                    if (w_scan_end) begin
                        if (r_op == OP_QUERY) begin
                            if (r_best_vld) begin
                                r_state <= ST_Q_DIFF;
                            end else begin
                                r_ms    <= YEAR_MS;
                                r_state <= ST_Q_EMIT;
                            end
                        end else begin
                            r_state <= r_best_vld ? ST_FIRE : ST_FLUSH;
                        end
                    end
                end

                ST_FIRE: begin
                    if (w_fire_go) begin
                        // release the previous fired slot, it is not the last
                        if (r_pend_vld) begin
                            r_out_vld <= 1'b1;
                            r_out <= '{kind: KIND_FIRED, slot: SLOT_W'(r_pend_slot),
                                       timeout_ms: '0, last: 1'b0};
                        end
                        if (!r_best_per) begin
                            r_active[r_best_idx] <= 1'b0;
                        end
                        r_done[r_best_idx] <= 1'b1;
                        r_pend_vld  <= 1'b1;
                        r_pend_slot <= r_best_idx;
                        r_fired     <= r_fired + 1'b1;
                        r_idx       <= '0;
                        r_cmp_vld   <= 1'b0;
                        r_best_vld  <= 1'b0;
                        r_state <= (r_fired == FIRE_W'(MAX_OUT - 1)) ? ST_FLUSH : ST_SCAN;
                    end
                end

                ST_FLUSH: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        if (r_pend_vld) begin
                            r_out <= '{kind: KIND_FIRED, slot: SLOT_W'(r_pend_slot),
                                       timeout_ms: '0, last: 1'b1};
                        end else begin
                            r_out <= '{kind: KIND_NONE_FIRED, slot: '0,
                                       timeout_ms: '0, last: 1'b1};
                        end
                        r_pend_vld <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end

                ST_Q_DIFF: begin
                    // a negative difference means the earliest timer is overdue
                    if (w_diff[NOW_W-1]) begin
                        r_ms    <= MIN_TIMEOUT_MS;
                        r_state <= ST_Q_EMIT;
                    end else begin
                        r_state <= ST_Q_DIV;
                    end
                end

                ST_Q_DIV: begin
                    if (!w_div_busy) begin
                        r_ms    <= (w_quo < MIN_TIMEOUT_MS) ? MIN_TIMEOUT_MS : w_quo;
                        r_state <= ST_Q_EMIT;
                    end
                end

                ST_Q_EMIT: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        r_out <= '{kind: KIND_MIN_TIMEOUT, slot: '0,
                                   timeout_ms: r_ms, last: 1'b1};
                        r_state <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/tmq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the timer expiry queue, bound to the top level.
// Depends on tmq_pkg and timer_expiry_queue.
module tmq_checker import tmq_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input t_kind           i_out_kind,
    input logic [SLOT_W-1:0] i_out_slot,
    input logic [MS_W-1:0] i_out_ms,
    input logic            i_out_last
);
    // an accepted beat drops ready in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after an accepted beat");

    // only fired beats can be followed by more beats of the same item
    a_nonlast_is_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> i_out_kind == KIND_FIRED)
        else $error("non-final result beat that is not a fired timer");

    // while idle, a waiting result must be the closing beat of its item
    a_idle_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_last)
        else $error("block took new work with an item still open");

    // query answers are floored, other beats carry no timeout
    a_timeout_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind == KIND_MIN_TIMEOUT && i_out_ms >= MIN_TIMEOUT_MS) ||
                        (i_out_kind != KIND_MIN_TIMEOUT && i_out_ms == '0))
        else $error("timeout field out of place");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) &&
            $stable(i_out_slot) && $stable(i_out_ms) && $stable(i_out_last))
        else $error("stalled result beat changed");
endmodule

bind timer_expiry_queue tmq_checker u_tmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.payload.kind),
    .i_out_slot  (o_out.payload.slot),
    .i_out_ms    (o_out.payload.timeout_ms),
    .i_out_last  (o_out.payload.last)
);

// ===== test/timer_expiry_queue_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for timer_expiry_queue: directed and random arm/kill/tick/query beats.
// Depends on tmq_pkg, tmq_in_if, tmq_out_if and the timer_expiry_queue RTL.
module timer_expiry_queue_test;
    import tmq_pkg::*;

    localparam int               SLOTS    = 16;
    localparam logic [NOW_W-1:0] NOW_MAX  = '1;
    localparam int               SETTLE   = 120;
    localparam int               LONG_OFF = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tmq_in_if  op_bus ();
    tmq_out_if result_bus ();

    timer_expiry_queue #(.TIMER_SLOTS(SLOTS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_bus),
        .o_out   (result_bus)
    );

    // Shadow copy of the slot table
    logic             slot_live     [SLOTS];
    logic [NOW_W-1:0] slot_expiry   [SLOTS];
    logic [IV_W-1:0]  slot_interval [SLOTS];
    logic             slot_repeat   [SLOTS];

    t_out_item        pending_results [$];
    logic [NOW_W-1:0] sim_now;

    bit gap_on;
    bit stall_on;
    int hold_cycles;
    int fail_count;
    int beats_sent;
    int results_seen;
    int fires_seen;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Work out every result beat that one accepted operation causes.
    task automatic compute_timer_results(input t_in_item it);
        t_out_item        r;
        t_out_item        burst [MAX_OUT];
        bit               fired [SLOTS];
        int               best;
        int               n;
        int               i;
        bit               searching;
        logic [NOW_W-1:0] diff;
        logic [MS_W-1:0]  ms;
        logic [IV_W-1:0]  iv;
        r = '0;
        r.last = 1'b1;
        case (it.operation)
            OP_ARM: begin
                best = -1;
                for (i = 0; i < SLOTS; i++) begin
                    if (best < 0 && !slot_live[i]) best = i;
                end
                if (best < 0) begin
                    r.kind = KIND_ERROR;
                end else begin
                    iv = IV_W'(64'(it.seconds) * 64'(US_PER_S));
                    slot_live[best]     = 1'b1;
                    slot_repeat[best]   = it.periodic;
                    slot_interval[best] = iv;
                    slot_expiry[best]   = it.now_us + 64'(iv);
                    r.kind = KIND_ARMED;
                    r.slot = SLOT_W'(best);
                end
                pending_results.push_back(r);
            end
            OP_KILL: begin
                r.slot = it.handle;
                if (slot_live[it.handle]) begin
                    slot_live[it.handle] = 1'b0;
                    r.kind = KIND_KILLED;
                end else begin
                    r.kind = KIND_ERROR;
                end
                pending_results.push_back(r);
            end
            OP_TICK: begin
                n = 0;
                searching = 1'b1;
                for (i = 0; i < SLOTS; i++) fired[i] = 1'b0;
                // A slot fires at most once per tick, even when re-armed into the past
                while (searching && n < MAX_OUT) begin
                    best = -1;
                    for (i = 0; i < SLOTS; i++) begin
                        if (slot_live[i] && !fired[i] && slot_expiry[i] <= it.now_us) begin
                            if (best < 0 || slot_expiry[i] < slot_expiry[best]) best = i;
                        end
                    end
                    if (best < 0) begin
                        searching = 1'b0;
                    end else begin
                        fired[best] = 1'b1;
                        if (slot_repeat[best])
                            slot_expiry[best] = it.now_us + 64'(slot_interval[best]);
                        else
                            slot_live[best] = 1'b0;
                        burst[n] = '0;
                        burst[n].kind = KIND_FIRED;
                        burst[n].slot = SLOT_W'(best);
                        n++;
                    end
                end
                if (n == 0) begin
                    r.kind = KIND_NONE_FIRED;
                    pending_results.push_back(r);
                end else begin
                    burst[n-1].last = 1'b1;
                    for (i = 0; i < n; i++) pending_results.push_back(burst[i]);
                end
            end
            default: begin
                best = -1;
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_live[i] && (best < 0 || slot_expiry[i] < slot_expiry[best]))
                        best = i;
                end
                if (best < 0) begin
                    ms = YEAR_MS;
                end else begin
                    // Past expiry shows up as a negative two's complement difference
                    diff = slot_expiry[best] - it.now_us;
                    if (diff[NOW_W-1]) begin
                        ms = MIN_TIMEOUT_MS;
                    end else begin
                        ms = MS_W'(diff / 64'(US_PER_MS));
                        if (ms < MIN_TIMEOUT_MS) ms = MIN_TIMEOUT_MS;
                    end
                end
                r.kind = KIND_MIN_TIMEOUT;
                r.timeout_ms = ms;
                pending_results.push_back(r);
            end
        endcase
    endtask

    // Offer one beat, hold it until accepted, then predict its results.
    task automatic send_beat(input t_in_item it);
        if (gap_on && $urandom_range(0, 3) == 0) begin
            op_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        op_bus.valid   <= 1'b1;
        op_bus.payload <= it;
        do @(posedge i_clk); while (!op_bus.ready);
        compute_timer_results(it);
        beats_sent++;
    endtask

    task automatic beat(input t_op op, input logic [NOW_W-1:0] now,
                        input logic [SECS_W-1:0] secs, input logic per,
                        input logic [HANDLE_W-1:0] h);
        t_in_item it;
        it.operation = op;
        it.now_us    = now;
        it.seconds   = secs;
        it.periodic  = per;
        it.handle    = h;
        send_beat(it);
    endtask

    // Drop valid after the last beat of a burst and wait for all results.
    task automatic end_burst();
        op_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_live_slot();
        int live [$];
        for (int i = 0; i < SLOTS; i++) if (slot_live[i]) live.push_back(i);
        if (live.size() == 0) return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic send_random_beat();
        t_in_item it;
        int       pick;
        int       live_slot;
        pick        = $urandom_range(0, 99);
        it.now_us   = {$urandom, $urandom};
        it.seconds  = SECS_W'($urandom);
        it.periodic = 1'($urandom);
        it.handle   = HANDLE_W'($urandom);
        // Mostly advancing time; now and then a wild timestamp as noise
        if ($urandom_range(0, 19) != 0) begin
            sim_now   = sim_now + 64'($urandom_range(0, 1500000));
            it.now_us = sim_now;
        end
        if (pick < 35) begin
            it.operation = OP_ARM;
            if ($urandom_range(0, 9) < 8) it.seconds = SECS_W'($urandom_range(0, 3));
        end else if (pick < 55) begin
            it.operation = OP_KILL;
            live_slot = pick_live_slot();
            if (live_slot >= 0 && $urandom_range(0, 3) != 0) it.handle = HANDLE_W'(live_slot);
        end else if (pick < 85) begin
            it.operation = OP_TICK;
        end else begin
            it.operation = OP_QUERY;
        end
        send_beat(it);
    endtask

    task automatic check_empty_table();
        beat(OP_QUERY, '0, '0, 1'b0, '0);
        beat(OP_TICK, NOW_MAX, '1, 1'b1, '1);
        beat(OP_KILL, '0, '0, 1'b0, 4'd0);
        beat(OP_KILL, NOW_MAX, '1, 1'b1, 4'd15);
        end_burst();
    endtask

    task automatic check_arm_and_query();
        beat(OP_ARM, 64'd1000, 16'd0, 1'b0, '0);
        // Expiry wraps past the top of the time range
        beat(OP_ARM, NOW_MAX, 16'hFFFF, 1'b1, '0);
        beat(OP_ARM, 64'd5000, 16'd0, 1'b1, '0);
        beat(OP_QUERY, 64'd0, '0, 1'b0, '0);
        beat(OP_QUERY, 64'd10000, '0, 1'b0, '0);
        end_burst();
    endtask

    task automatic check_tick_order();
        beat(OP_TICK, 64'd5000, '0, 1'b0, '0);
        beat(OP_TICK, 64'd5000, '0, 1'b0, '0);
        end_burst();
    endtask

    task automatic check_kill();
        beat(OP_KILL, 64'd6000, '0, 1'b0, 4'd2);
        beat(OP_KILL, 64'd6000, '0, 1'b0, 4'd2);
        beat(OP_QUERY, 64'd0, '0, 1'b0, '0);
        end_burst();
    endtask

    task automatic check_table_full();
        for (int i = 0; i < SLOTS - 1; i++)
            beat(OP_ARM, 64'd0, SECS_W'(i % 3), 1'(i), '0);
        beat(OP_ARM, 64'd0, 16'd1, 1'b0, '0);
        // Everything is due: ties resolve to the lowest slot
        beat(OP_TICK, NOW_MAX, '0, 1'b0, '0);
        beat(OP_QUERY, NOW_MAX, '0, 1'b0, '0);
        end_burst();
    endtask

    task automatic run_random_traffic(input int count, input logic [NOW_W-1:0] start);
        sim_now = start;
        for (int i = 0; i < count; i++) send_random_beat();
        end_burst();
    endtask

    // Hold the result side off while the sender keeps offering beats.
    task automatic check_backpressure();
        hold_cycles = LONG_OFF;
        for (int i = 0; i < 30; i++) send_random_beat();
        end_burst();
    endtask

    // Result side ready: random bursts of stall, or a long hold-off on request
    initial begin
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                result_bus.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                result_bus.ready <= 1'b1;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                result_bus.ready <= 1'b1;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (result_bus.valid && result_bus.ready) begin
            results_seen++;
            if (result_bus.payload.kind == KIND_FIRED) fires_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: kind %0d slot %0d",
                       result_bus.payload.kind, result_bus.payload.slot);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (result_bus.payload.kind !== want.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d",
                           want.kind, result_bus.payload.kind);
                    fail_count++;
                end
                if (result_bus.payload.slot !== want.slot) begin
                    $error("slot mismatch: expected %0d, actual %0d",
                           want.slot, result_bus.payload.slot);
                    fail_count++;
                end
                if (result_bus.payload.timeout_ms !== want.timeout_ms) begin
                    $error("timeout_ms mismatch: expected %0d, actual %0d",
                           want.timeout_ms, result_bus.payload.timeout_ms);
                    fail_count++;
                end
                if (result_bus.payload.last !== want.last) begin
                    $error("last mismatch: expected %0d, actual %0d",
                           want.last, result_bus.payload.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i]     = 1'b0;
            slot_expiry[i]   = '0;
            slot_interval[i] = '0;
            slot_repeat[i]   = 1'b0;
        end
        gap_on       = 1'b0;
        stall_on     = 1'b0;
        hold_cycles  = 0;
        fail_count   = 0;
        beats_sent   = 0;
        results_seen = 0;
        fires_seen   = 0;
        sim_now      = '0;
        i_rst_n        <= 1'b0;
        op_bus.valid   <= 1'b0;
        op_bus.payload <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_on   = 1'b1;
        stall_on = 1'b1;
        check_empty_table();
        check_arm_and_query();
        check_tick_order();
        check_kill();
        check_table_full();
        run_random_traffic(270, {32'($urandom_range(0, 255)), 32'($urandom)});
        gap_on   = 1'b0;
        check_backpressure();
        // Quiet finish, running across the wrap of the time range
        stall_on = 1'b0;
        run_random_traffic(80, NOW_MAX - 64'd30000000);

        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d operation beats (arm, kill, tick, query) and %0d result beats,",
                 beats_sent, results_seen);
        $display("including %0d fired slots, a full table, time wrap and a long result stall.",
                 fires_seen);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
